/* rtl/rv_pkg.sv */
`default_nettype none

package rv_pkg;

	localparam int MAX_ROW_LEN = 1024;

	// word field widths
	localparam int SAMPLE_W = 16;
	localparam int VAR_W    = 31;
	localparam int ELEM_W   = 11;

	// accumulator widths
	localparam int CNT_W = $clog2(MAX_ROW_LEN + 1);
	localparam int SUM_W = 26;
	localparam int SQ_W  = 41;

	// finishing arithmetic
	localparam int MULA_W  = SQ_W;
	localparam int MULB_W  = SUM_W;
	localparam int PROD_W  = MULA_W + MULB_W;
	localparam int NUM_W   = CNT_W + SQ_W;
	localparam int DEN_W   = 2 * CNT_W;
	localparam int STEP_W  = $clog2(NUM_W);

	typedef enum logic [2:0] {
		ST_ACC,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_D,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} rv_state_t;

	typedef enum logic [1:0] {
		MSEL_SUMSQ,
		MSEL_SUMSQR,
		MSEL_DEN
	} rv_msel_t;

endpackage

`default_nettype wire

/* rtl/rv_if.sv */
`default_nettype none

interface rv_in_if;
	import rv_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_in_row;

	modport source (output valid, output sample, output last_in_row, input ready);
	modport sink (input valid, input sample, input last_in_row, output ready);
endinterface

interface rv_out_if;
	import rv_pkg::*;

	logic              valid;
	logic              ready;
	logic [VAR_W-1:0]  variance;
	logic [ELEM_W-1:0] element_count;
	logic              divide_error;
	logic              row_overflow;

	modport source (output valid, output variance, output element_count,
		output divide_error, output row_overflow, input ready);
	modport sink (input valid, input variance, input element_count,
		input divide_error, input row_overflow, output ready);
endinterface

`default_nettype wire

/* rtl/row_variance.sv */
`default_nettype none

// Channel   Dir  Fields                                              Flow
// samples   in   sample[15:0] signed, last_in_row                    valid/ready
// results   out  variance[30:0], element_count[10:0],
//                divide_error, row_overflow                          valid/ready
// cfg       in   cfg_we, cfg_wdata (sample_mode)                     write only
//
// Samples of a row are taken one per cycle; each sample is registered and squared one stage behind.
// Row end: three passes through one shared 41x26 multiplier, then a restoring divider
// that retires one quotient bit a cycle.
// Ready stays low from the last sample until the result enters the output register.
// A result waiting on results.ready does not stop the next row from accumulating.
// arst_n clears control state, accumulators and sample_mode.

module row_variance (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	rv_in_if.sink     samples,
	rv_out_if.source  results
);
	import rv_pkg::*;

	rv_state_t state_q, state_d;
	rv_msel_t  msel;

	logic mode_q;

	// input stage
	logic                       pend_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       last_s1;
	logic                       accept;

	// accumulators
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sumsq_q;
	logic             ovf_q;

	logic signed [2*SAMPLE_W-1:0] square;
	logic [SUM_W-1:0]             abs_sum;
	logic [CNT_W-1:0]             div_n;

	// shared multiplier
	logic [MULA_W-1:0] mul_a;
	logic [MULB_W-1:0] mul_b;
	logic [PROD_W-1:0] prod_s1;

	logic [NUM_W-1:0] a_q, b_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;

	logic [DEN_W:0] trial;
	logic           trial_ok;
	logic           div_last;
	logic           acc_stall;
	logic           out_load;
	logic           derr;

	logic [VAR_W-1:0] var_val;

	logic             out_valid_q;
	logic [VAR_W-1:0] var_q;
	logic [ELEM_W-1:0] elem_q;
	logic             derr_q;
	logic             ovf_out_q;

	assign accept    = samples.valid && samples.ready;
	assign acc_stall = pend_s1 && last_s1;
	assign square    = sample_s1 * sample_s1;
	assign abs_sum   = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign div_n     = mode_q ? (count_q - 1'b1) : count_q;
	assign derr      = mode_q && (count_q == CNT_W'(1));

	assign trial    = {rem_q, quo_q[NUM_W-1]};
	assign trial_ok = trial >= {1'b0, den_q};
	assign div_last = step_q == STEP_W'(NUM_W - 1);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	// saturate the quotient, zero it when there is no divisor
	always_comb begin
		if (derr || den_q == '0) begin
			var_val = '0;
		end else if (|quo_q[NUM_W-1:VAR_W]) begin
			var_val = '1;
		end else begin
			var_val = quo_q[VAR_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACC:   if (acc_stall) state_d = ST_MUL_A;
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_MUL_D;
			ST_MUL_D: state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_DIV;
			ST_DIV:   if (div_last) state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_ACC;
			default:  state_d = ST_ACC;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		samples.ready = 1'b0;
		msel          = MSEL_SUMSQ;
		unique case (state_q)
			ST_ACC:   samples.ready = !acc_stall;
			ST_MUL_A: msel = MSEL_SUMSQ;
			ST_MUL_B: msel = MSEL_SUMSQR;
			ST_MUL_D: msel = MSEL_DEN;
			default:  msel = MSEL_SUMSQ;
		endcase
	end

	always_comb begin
		unique case (msel)
			MSEL_SUMSQ: begin
				mul_a = sumsq_q;
				mul_b = MULB_W'(count_q);
			end
			MSEL_SUMSQR: begin
				mul_a = MULA_W'(abs_sum);
				mul_b = abs_sum;
			end
			MSEL_DEN: begin
				mul_a = MULA_W'(count_q);
				mul_b = MULB_W'(div_n);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		sample_s1 <= samples.sample;
		last_s1   <= samples.last_in_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			mode_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= accept;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
		end
	end

	// accumulate, drop past capacity, clear when the result enters the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			ovf_q   <= 1'b0;
		end else if (out_load) begin
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			ovf_q   <= 1'b0;
		end else if (state_q == ST_ACC && pend_s1) begin
			if (count_q < CNT_W'(MAX_ROW_LEN)) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(sample_s1);
				sumsq_q <= sumsq_q + SQ_W'(unsigned'(square));
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// finishing datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_LOAD) begin
			step_q <= '0;
		end else if (state_q == ST_DIV) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_MUL_B: a_q <= prod_s1[NUM_W-1:0];
			ST_MUL_D: b_q <= prod_s1[NUM_W-1:0];
			ST_LOAD: begin
				den_q <= prod_s1[DEN_W-1:0];
				quo_q <= (a_q > b_q) ? (a_q - b_q) : '0;
				rem_q <= '0;
			end
			ST_DIV: begin
				quo_q <= {quo_q[NUM_W-2:0], trial_ok};
				rem_q <= trial_ok ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			var_q     <= var_val;
			elem_q    <= ELEM_W'(count_q);
			derr_q    <= derr;
			ovf_out_q <= ovf_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.variance      = var_q;
	assign results.element_count = elem_q;
	assign results.divide_error  = derr_q;
	assign results.row_overflow  = ovf_out_q;

	a_last_starts_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && acc_stall) |=> state_q == ST_MUL_A)
		else $error("row end did not start the finishing sequence");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ROW_LEN))
		else $error("sample count beyond capacity");

	a_drop_at_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == CNT_W'(MAX_ROW_LEN))
		else $error("drop flagged before the row was full");

	a_derr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && derr_q) |-> var_q == '0)
		else $error("divide error with nonzero variance");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACC) |-> !pend_s1 || (last_s1 && state_q == ST_MUL_A))
		else $error("sample taken while finishing a row");

endmodule

`default_nettype wire
